### sv/lps_pkg.sv
package lps_pkg;

    localparam int LedCount   = 9;
    localparam int PatternTop = 12;
    localparam int ModSteps   = 8;

    // reciprocal of 100 scaled by 2^19, exact for products below 25600
    localparam int RecipShift = 19;
    localparam logic [12:0] Recip100 = 13'd5243;

    typedef enum logic [2:0] {
        CFG_BASE_RED     = 3'd0,
        CFG_BASE_GREEN   = 3'd1,
        CFG_BASE_BLUE    = 3'd2,
        CFG_GLOBAL_BRI   = 3'd3,
        CFG_FRAME_INT    = 3'd4,
        CFG_ROTATION_INT = 3'd5,
        CFG_UNLOCK_MASK  = 3'd6,
        CFG_RANDOM_SEED  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_HOLD    = 2'd1,
        KIND_RANDOM  = 2'd2,
        KIND_RESUME  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD, S_MOD_CMD, S_CHECK, S_MOD_SP1, S_MOD_PAL,
        S_PULSE1, S_PULSE2, S_R10, S_FILL, S_EMIT, S_ROT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       cmd_exec;
        logic       draw;
        logic       mod_cnt;
        logic [3:0] mod_m;
        logic       pat_load;
        logic       pos_save;
        logic       frame_mark;
        logic       prod1;
        logic       prod2;
        logic       r10_write;
        logic       fill;
        logic       rot;
        logic [3:0] pix;
        logic [1:0] chan;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] pattern;
        logic       frame_due;
        logic       mod_done;
    } t_status;

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'd0:    c = {8'd255, 8'd0,   8'd0};
            4'd1:    c = {8'd255, 8'd127, 8'd0};
            4'd2:    c = {8'd255, 8'd130, 8'd0};
            4'd3:    c = {8'd0,   8'd255, 8'd0};
            4'd4:    c = {8'd0,   8'd0,   8'd255};
            4'd5:    c = {8'd75,  8'd0,   8'd130};
            4'd6:    c = {8'd148, 8'd0,   8'd211};
            4'd7:    c = {8'd255, 8'd255, 8'd255};
            4'd8:    c = {8'd255, 8'd20,  8'd147};
            default: c = 24'd0;
        endcase
        return c;
    endfunction

endpackage

### sv/lps_ctrl.sv
module lps_ctrl
    import lps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_pix;
    logic [1:0] r_chan;
    logic       w_in_acc, w_out_acc, w_r10_end;

    assign w_in_acc  = i_in_valid && (r_state == S_IDLE);
    assign w_out_acc = (r_state == S_EMIT) && !i_out_stall;
    assign w_r10_end = (r_pix == 4'(LedCount - 1)) && (r_chan == 2'd2);

    // state register and pixel/channel counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pix   <= '0;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CHECK || r_state == S_FILL) begin
                r_pix  <= '0;
                r_chan <= '0;
            end else if (r_state == S_R10) begin
                if (r_chan == 2'd2) begin
                    r_chan <= '0;
                    r_pix  <= r_pix + 4'd1;
                end else begin
                    r_chan <= r_chan + 2'd1;
                end
            end else if (w_out_acc) begin
                r_pix <= r_pix + 4'd1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = (i_status.kind == KIND_TICK) ? S_CHECK : S_CMD;
            end
            S_CMD: begin
                n_state = (i_status.kind == KIND_RANDOM) ? S_MOD_CMD : S_IDLE;
            end
            S_MOD_CMD: begin
                if (i_status.mod_done) n_state = S_IDLE;
            end
            S_CHECK: begin
                if (!i_status.frame_due) n_state = S_ROT;
                else begin
                    case (i_status.pattern)
                        4'd5:         n_state = S_MOD_SP1;
                        4'd8:         n_state = S_PULSE1;
                        4'd9, 4'd12:  n_state = S_MOD_PAL;
                        4'd10:        n_state = S_R10;
                        default:      n_state = S_FILL;
                    endcase
                end
            end
            S_MOD_SP1: begin
                if (i_status.mod_done) n_state = S_MOD_PAL;
            end
            S_MOD_PAL: begin
                if (i_status.mod_done) n_state = S_FILL;
            end
            S_PULSE1: n_state = S_PULSE2;
            S_PULSE2: n_state = S_FILL;
            S_R10: begin
                if (w_r10_end) n_state = S_FILL;
            end
            S_FILL: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_acc && r_pix == 4'(LedCount - 1)) n_state = S_ROT;
            end
            S_ROT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.pix   = r_pix;
        o_cmd.chan  = r_chan;
        o_cmd.mod_m = 4'd10;
        o_cmd.latch = w_in_acc;
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_EMIT);
        unique case (r_state)
            S_CMD: begin
                o_cmd.cmd_exec = 1'b1;
                if (i_status.kind == KIND_RANDOM) begin
                    o_cmd.draw  = 1'b1;
                    o_cmd.mod_m = 4'(PatternTop + 1);
                end
            end
            S_MOD_CMD: o_cmd.pat_load = i_status.mod_done;
            S_CHECK: begin
                if (i_status.frame_due) begin
                    o_cmd.frame_mark = 1'b1;
                    case (i_status.pattern)
                        4'd5, 4'd12: o_cmd.draw = 1'b1;
                        4'd9: begin
                            o_cmd.mod_cnt = 1'b1;
                            o_cmd.mod_m   = 4'(LedCount);
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD_SP1: begin
                if (i_status.mod_done) begin
                    o_cmd.pos_save = 1'b1;
                    o_cmd.draw     = 1'b1;
                end
            end
            S_PULSE1: o_cmd.prod1     = 1'b1;
            S_PULSE2: o_cmd.prod2     = 1'b1;
            S_R10:    o_cmd.r10_write = 1'b1;
            S_FILL:   o_cmd.fill      = 1'b1;
            S_ROT:    o_cmd.rot       = 1'b1;
            default: ;
        endcase
    end

endmodule

### sv/lps_dp.sv
module lps_dp
    import lps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now_ms,
    input  logic [3:0]  i_pattern_id,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_brightness,
    output logic [3:0]  o_pattern_shown
);

    // configuration
    logic [7:0]  r_base_r, r_base_g, r_base_b, r_gbri;
    logic [15:0] r_frame_int;
    logic [31:0] r_rot_int;
    logic [3:0]  r_unlock;

    // sequencer state
    logic [3:0]  r_pattern;
    logic [8:0]  r_c;
    logic [6:0]  r_speed;
    logic [31:0] r_last_frame, r_last_rot;
    logic        r_ca, r_hold, r_rel;
    logic [3:0]  r_rel_cnt;
    logic [7:0]  r_strip;
    logic [31:0] r_rng;

    // item and work registers
    logic [1:0]  r_kind;
    logic [31:0] r_now;
    logic [3:0]  r_pid;
    logic [22:0] r_period;
    logic [31:0] r_mod_val;
    logic [3:0]  r_mod_rem, r_mod_m, r_mod_cnt, r_pos;
    logic [14:0] r_prod1;
    logic [27:0] r_prod2;
    logic [23:0] r_px [LedCount];

    logic [31:0] w_rng_next;
    logic        w_rot_due;
    logic [23:0] w_base, w_wheel;
    logic [8:0]  w_w, w_wd;
    logic [7:0]  w_w3;
    logic [7:0]  w_lvl;
    logic [9:0]  w_c1;
    logic [8:0]  n_c;
    logic        n_ca;
    logic [6:0]  n_speed;
    logic [23:0] n_px [LedCount];

    function automatic logic [3:0] mod_step(input logic [7:0] v, input logic [3:0] m);
        logic [7:0] x;
        x = v;
        for (int k = 3; k >= 0; k--) begin
            if (x >= ({4'd0, m} << k)) x = x - ({4'd0, m} << k);
        end
        return x[3:0];
    endfunction

    function automatic logic [3:0] next_pattern(input logic [3:0] p0, input logic [3:0] um);
        logic [4:0] p;
        p = {1'b0, p0} + 5'd1;
        for (int k = 0; k < 4; k++) begin
            if (p >= 5'd9 && p <= 5'd12 && !um[2'(p - 5'd9)]) p = p + 5'd1;
        end
        if (p > 5'(PatternTop)) p = '0;
        return p[3:0];
    endfunction

    assign w_rng_next = xorshift(r_rng);
    assign w_rot_due  = ((r_now - r_last_rot) >= r_rot_int) && r_ca;
    assign w_base     = {r_base_r, r_base_g, r_base_b};
    assign w_c1       = {1'b0, r_c} + 10'd1;

    // kind of the item being taken is seen in its accept cycle
    assign o_status.kind      = i_cmd.latch ? i_kind : r_kind;
    assign o_status.pattern   = r_pattern;
    assign o_status.frame_due = (r_now - r_last_frame) >= {9'd0, r_period};
    assign o_status.mod_done  = (r_mod_cnt == 4'(ModSteps));

    assign o_red           = r_px[i_cmd.pix][23:16];
    assign o_green         = r_px[i_cmd.pix][15:8];
    assign o_blue          = r_px[i_cmd.pix][7:0];
    assign o_brightness    = r_strip;
    assign o_pattern_shown = r_pattern;

    // pulse level
    always_comb begin
        if (r_c > 9'd200)      w_lvl = 8'd0;
        else if (r_c > 9'd100) w_lvl = 8'(9'd200 - r_c);
        else                   w_lvl = r_c[7:0];
    end

    // color wheel
    always_comb begin
        if (r_c >= 9'd510)      w_w = r_c - 9'd510;
        else if (r_c >= 9'd255) w_w = r_c - 9'd255;
        else                    w_w = r_c;
        if (w_w < 9'd85)       w_wd = w_w;
        else if (w_w < 9'd170) w_wd = w_w - 9'd85;
        else                   w_wd = w_w - 9'd170;
        w_w3 = 8'(w_wd * 9'd3);
        if (w_w < 9'd85)       w_wheel = {w_w3, 8'd255 - w_w3, 8'd0};
        else if (w_w < 9'd170) w_wheel = {8'd255 - w_w3, 8'd0, w_w3};
        else                   w_wheel = {8'd0, w_w3, 8'd255 - w_w3};
    end

    // frame render: pixels, counter, flags
    always_comb begin
        logic [4:0] pi;
        n_c     = r_c;
        n_ca    = r_ca;
        n_speed = 7'd100;
        for (int i = 0; i < LedCount; i++) begin
            n_px[i] = 24'd0;
            pi = 5'(i) + {1'b0, r_mod_rem};
            if (pi >= 5'(LedCount)) pi = pi - 5'(LedCount);
            case (r_pattern)
                4'd1, 4'd2: if (r_c == 9'(i)) n_px[i] = w_base;
                4'd3:       if (r_c == 9'd0) n_px[i] = w_base;
                4'd4, 4'd8: n_px[i] = w_base;
                4'd5: if (r_pos == 4'(i) || r_mod_rem == 4'(i)) n_px[i] = w_base;
                4'd6: if (r_c < 9'd4 && (r_c == 9'(i) || r_c == 9'(LedCount - 1 - i)))
                          n_px[i] = w_base;
                4'd7: if ((r_c != 9'd0) == (i % 2 == 0)) n_px[i] = w_base;
                4'd9:  n_px[i] = palette(pi[3:0]);
                4'd10: n_px[i] = r_px[i];
                4'd11: n_px[i] = w_wheel;
                4'd12: n_px[i] = palette(r_mod_rem);
                default: ;
            endcase
        end
        case (r_pattern)
            4'd1: begin
                n_speed = 7'd1;
                n_ca    = (w_c1 >= 10'd10);
                n_c     = (w_c1 >= 10'd10) ? 9'd0 : w_c1[8:0];
            end
            4'd2: begin
                n_speed = 7'd1;
                n_ca    = (r_c == 9'd0);
                n_c     = (r_c == 9'd0) ? 9'd10 : r_c - 9'd1;
            end
            4'd3: begin
                n_speed = 7'd3;
                n_c     = (r_c > 9'd0) ? 9'd0 : 9'd1;
            end
            4'd4: n_speed = 7'd20;
            4'd5: n_speed = 7'd1;
            4'd6: begin
                n_speed = 7'd2;
                if (w_c1 > 10'd4) begin
                    n_c  = 9'd0;
                    n_ca = 1'b1;
                end else begin
                    n_c = w_c1[8:0];
                end
            end
            4'd7: begin
                n_speed = 7'd2;
                n_c     = (r_c != 9'd0) ? 9'd0 : 9'd1;
            end
            4'd8: begin
                n_speed = 7'd0;
                n_ca    = (w_c1 >= 10'd200);
                n_c     = (w_c1 >= 10'd200) ? 9'd0 : w_c1[8:0];
            end
            4'd9: begin
                n_speed = 7'd2;
                n_c     = (w_c1 > 10'd9) ? 9'd0 : w_c1[8:0];
            end
            4'd10: n_speed = 7'd1;
            4'd11: begin
                n_speed = 7'd1;
                n_ca    = (w_c1 > 10'd255);
                n_c     = (w_c1 > 10'd255) ? 9'd0 : w_c1[8:0];
            end
            4'd12: begin
                n_speed = 7'd2;
                n_c     = {5'd0, r_mod_rem};
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_r     <= 8'd255;
            r_base_g     <= 8'd255;
            r_base_b     <= 8'd255;
            r_gbri       <= 8'd30;
            r_frame_int  <= 16'd100;
            r_rot_int    <= 32'd10000;
            r_unlock     <= '0;
            r_pattern    <= 4'd1;
            r_c          <= '0;
            r_speed      <= 7'd1;
            r_last_frame <= '0;
            r_last_rot   <= '0;
            r_ca         <= 1'b1;
            r_hold       <= 1'b0;
            r_rel        <= 1'b0;
            r_rel_cnt    <= '0;
            r_strip      <= 8'd30;
            r_rng        <= 32'd1;
            r_mod_cnt    <= 4'(ModSteps);
        end else begin
            // config writes
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_BASE_RED:     r_base_r    <= i_cfg_data[7:0];
                    CFG_BASE_GREEN:   r_base_g    <= i_cfg_data[7:0];
                    CFG_BASE_BLUE:    r_base_b    <= i_cfg_data[7:0];
                    CFG_GLOBAL_BRI:   r_gbri      <= i_cfg_data[7:0];
                    CFG_FRAME_INT:    r_frame_int <= i_cfg_data[15:0];
                    CFG_ROTATION_INT: r_rot_int   <= i_cfg_data;
                    CFG_UNLOCK_MASK:  r_unlock    <= i_cfg_data[3:0];
                    CFG_RANDOM_SEED:  r_rng       <= i_cfg_data;
                    default: ;
                endcase
            end
            // commands
            if (i_cmd.cmd_exec) begin
                r_rel <= 1'b1;
                if (r_kind == KIND_HOLD) begin
                    r_hold    <= 1'b1;
                    r_pattern <= (r_pid > 4'(PatternTop)) ? 4'(PatternTop) : r_pid;
                end else begin
                    r_hold <= 1'b0;
                end
            end
            if (i_cmd.pat_load) r_pattern <= r_mod_rem;
            // random generator
            if (i_cmd.draw || i_cmd.r10_write) r_rng <= w_rng_next;
            // modulo unit, one nibble per cycle
            if (i_cmd.draw || i_cmd.mod_cnt) begin
                r_mod_val <= i_cmd.draw ? w_rng_next : {23'd0, r_c};
                r_mod_m   <= i_cmd.mod_m;
                r_mod_cnt <= '0;
            end else if (r_mod_cnt != 4'(ModSteps)) begin
                r_mod_val <= r_mod_val << 4;
                r_mod_cnt <= r_mod_cnt + 4'd1;
            end
            if (i_cmd.frame_mark) r_last_frame <= r_now;
            // frame render
            if (i_cmd.fill) begin
                r_c     <= n_c;
                r_ca    <= n_ca;
                r_speed <= n_speed;
                if (r_pattern == 4'd8) r_strip <= r_prod2[RecipShift+7:RecipShift];
            end
            // rotation timer
            if (i_cmd.rot && w_rot_due) begin
                r_last_rot <= r_now;
                r_strip    <= r_gbri;
                if (!r_hold) begin
                    r_pattern <= next_pattern(r_pattern, r_unlock);
                    r_c       <= '0;
                end else if (r_rel) begin
                    if (r_rel_cnt + 4'd1 > 4'd10) begin
                        r_rel     <= 1'b0;
                        r_hold    <= 1'b0;
                        r_rel_cnt <= '0;
                    end else begin
                        r_rel_cnt <= r_rel_cnt + 4'd1;
                    end
                end
            end
        end
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        r_period <= {7'd0, r_frame_int} * {16'd0, r_speed};
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_now  <= i_now_ms;
            r_pid  <= i_pattern_id;
        end
        if (i_cmd.draw || i_cmd.mod_cnt) begin
            r_mod_rem <= '0;
        end else if (r_mod_cnt != 4'(ModSteps)) begin
            r_mod_rem <= mod_step({r_mod_rem, r_mod_val[31:28]}, r_mod_m);
        end
        if (i_cmd.pos_save) r_pos <= r_mod_rem;
        if (i_cmd.prod1) r_prod1 <= {7'd0, r_gbri} * {7'd0, w_lvl};
        if (i_cmd.prod2) r_prod2 <= {13'd0, r_prod1} * {15'd0, Recip100};
        if (i_cmd.fill) begin
            for (int i = 0; i < LedCount; i++) r_px[i] <= n_px[i];
        end else if (i_cmd.r10_write) begin
            case (i_cmd.chan)
                2'd0:    r_px[i_cmd.pix][23:16] <= w_rng_next[7:0];
                2'd1:    r_px[i_cmd.pix][15:8]  <= w_rng_next[7:0];
                default: r_px[i_cmd.pix][7:0]   <= w_rng_next[7:0];
            endcase
        end
    end

endmodule

### sv/led_pattern_sequencer.sv
// LED pattern sequencer for a 9-pixel strip: one item is taken at a time. A
// command item is executed; a random-pattern command then runs the nibble
// modulo unit to pick the pattern. A tick that renders no frame goes to the
// rotation timer. A frame does its render work (pulse products, palette via
// the modulo unit, sparkle via it twice, random colors channel by channel),
// then nine pixel items, one per cycle unless the output stalls, then rotation.
module led_pattern_sequencer
    import lps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now_ms,
    input  logic [3:0]  i_pattern_id,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_pixel_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_brightness,
    output logic [3:0]  o_pattern_shown,
    output logic        o_last
);

    t_cmd    w_cmd;
    t_status w_status;

    lps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    lps_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_now_ms        (i_now_ms),
        .i_pattern_id    (i_pattern_id),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_brightness    (o_brightness),
        .o_pattern_shown (o_pattern_shown)
    );

    // pixel index and end of frame
    assign o_pixel_index = w_cmd.pix;
    assign o_last        = (w_cmd.pix == 4'(LedCount - 1));

    // no new item while a frame is going out
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("item accepted during frame");

    a_pix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_index < 4'(LedCount) && o_pattern_shown <= 4'(PatternTop)))
        else $error("pixel or pattern out of range");

    // after the last pixel is taken the frame ends
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> !o_out_valid)
        else $error("frame continued past last pixel");

endmodule

### tb/led_pattern_sequencer_tb.sv
`default_nettype none

module led_pattern_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StripLen  = 9;
    localparam int TopPat    = 12;
    localparam int IdlePct   = 29;
    localparam int SettleCyc = 100;
    localparam int StuckMax  = 20000;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic [3:0]  pattern_id;
    } cmd_item_t;

    typedef struct {
        logic [3:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] brightness;
        logic [3:0] pattern_shown;
        logic       last;
    } pixel_item_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_kind;
    logic [31:0] i_now_ms;
    logic [3:0]  i_pattern_id;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_pixel_index;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_brightness;
    logic [3:0]  o_pattern_shown;
    logic        o_last;

    led_pattern_sequencer dut (.*);

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    cmd_item_t   pending_cmds[$];
    pixel_item_t expected_pixels[$];
    int          mismatches = 0;
    logic        in_fire = 1'b0;
    logic        calm = 1'b0;
    int          stuck_cycles = 0;
    logic [31:0] clock_ms;

    // shadow of the block: configuration
    logic [7:0]  user_r, user_g, user_b, strip_level;
    logic [15:0] frame_gap;
    logic [31:0] rotate_gap;
    logic [3:0]  unlocked;

    // shadow of the block: state
    logic [3:0]  cur_pat;
    logic [8:0]  steps;
    logic [6:0]  speed;
    logic [31:0] frame_stamp, rotate_stamp;
    logic        may_change, holding, release_armed;
    logic [3:0]  release_cnt;
    logic [7:0]  shown_level;
    logic [31:0] lfsr;
    logic [7:0]  frame_rgb[StripLen][3];

    function automatic logic [23:0] swatch(input logic [3:0] n);
        case (n)
            4'd0:    return {8'd255, 8'd0,   8'd0};
            4'd1:    return {8'd255, 8'd127, 8'd0};
            4'd2:    return {8'd255, 8'd130, 8'd0};
            4'd3:    return {8'd0,   8'd255, 8'd0};
            4'd4:    return {8'd0,   8'd0,   8'd255};
            4'd5:    return {8'd75,  8'd0,   8'd130};
            4'd6:    return {8'd148, 8'd0,   8'd211};
            4'd7:    return {8'd255, 8'd255, 8'd255};
            4'd8:    return {8'd255, 8'd20,  8'd147};
            default: return 24'd0;
        endcase
    endfunction

    function automatic logic [31:0] next_random();
        logic [31:0] x;
        x = lfsr;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        lfsr = x;
        return x;
    endfunction

    function automatic void paint(input int unsigned idx, input logic [23:0] rgb);
        if (idx < StripLen) begin
            frame_rgb[idx][0] = rgb[23:16];
            frame_rgb[idx][1] = rgb[15:8];
            frame_rgb[idx][2] = rgb[7:0];
        end
    endfunction

    function automatic void paint_all(input logic [23:0] rgb);
        for (int i = 0; i < StripLen; i++) paint(i, rgb);
    endfunction

    // one frame of the current pattern
    function automatic void draw_frame();
        int unsigned c, w, lvl;
        logic [23:0] user;
        c = steps;
        user = {user_r, user_g, user_b};
        paint_all(24'd0);
        case (cur_pat)
            4'd1: begin
                may_change = 1'b0;
                paint(c, user);
                c++;
                if (c >= StripLen + 1) begin c = 0; may_change = 1'b1; end
                speed = 1;
            end
            4'd2: begin
                may_change = 1'b0;
                paint(c, user);
                if (c == 0) begin may_change = 1'b1; c = StripLen + 1; end
                else c--;
                speed = 1;
            end
            4'd3: begin
                if (c > 0) c = 0;
                else begin c = 1; paint_all(user); end
                speed = 3;
            end
            4'd4: begin
                paint_all(user);
                speed = 20;
            end
            4'd5: begin
                paint(next_random() % 10, user);
                paint(next_random() % 10, user);
                speed = 1;
            end
            4'd6: begin
                if (c < 4) begin paint(c, user); paint(StripLen - 1 - c, user); end
                c++;
                if (c > 4) begin c = 0; may_change = 1'b1; end
                speed = 2;
            end
            4'd7: begin
                for (int i = (c != 0) ? 0 : 1; i < StripLen; i += 2) paint(i, user);
                c = (c != 0) ? 0 : 1;
                speed = 2;
            end
            4'd8: begin
                may_change = 1'b0;
                paint_all(user);
                if (c > 100) lvl = (c > 200) ? 0 : 200 - c;
                else lvl = c;
                shown_level = 8'((strip_level * lvl) / 100);
                c++;
                if (c >= 200) begin may_change = 1'b1; c = 0; end
                speed = 0;
            end
            4'd9: begin
                for (int i = 0; i < StripLen; i++) paint(i, swatch(4'((i + c) % 9)));
                c++;
                if (c > 9) c = 0;
                speed = 2;
            end
            4'd10: begin
                for (int i = 0; i < StripLen; i++) begin
                    frame_rgb[i][0] = 8'(next_random());
                    frame_rgb[i][1] = 8'(next_random());
                    frame_rgb[i][2] = 8'(next_random());
                end
                speed = 1;
            end
            4'd11: begin
                may_change = 1'b0;
                w = c % 255;
                if (w < 85) paint_all({8'(w * 3), 8'(255 - w * 3), 8'd0});
                else if (w < 170) begin
                    w -= 85;
                    paint_all({8'(255 - w * 3), 8'd0, 8'(w * 3)});
                end else begin
                    w -= 170;
                    paint_all({8'd0, 8'(w * 3), 8'(255 - w * 3)});
                end
                c++;
                if (c > 255) begin c = 0; may_change = 1'b1; end
                speed = 1;
            end
            4'd12: begin
                c = next_random() % 10;
                paint_all(swatch(4'(c)));
                speed = 2;
            end
            default: speed = 100;
        endcase
        steps = 9'(c);
    endfunction

    function automatic logic is_locked(input int unsigned p);
        if (p < 9 || p > TopPat) return 1'b0;
        return !unlocked[p - 9];
    endfunction

    // expected pixels for one accepted item
    function automatic void predict_item(input cmd_item_t it);
        logic [3:0]  shown;
        logic [31:0] since;
        int unsigned p;
        pixel_item_t px;
        case (it.kind)
            lps_pkg::KIND_HOLD: begin
                holding = 1'b1;
                release_armed = 1'b1;
                cur_pat = (it.pattern_id > TopPat) ? 4'(TopPat) : it.pattern_id;
            end
            lps_pkg::KIND_RANDOM: begin
                holding = 1'b0;
                release_armed = 1'b1;
                cur_pat = 4'(next_random() % (TopPat + 1));
            end
            lps_pkg::KIND_RESUME: begin
                holding = 1'b0;
                release_armed = 1'b1;
            end
            default: begin
                since = it.now_ms - frame_stamp;
                if (64'(since) >= 64'(frame_gap) * 64'(speed)) begin
                    shown = cur_pat;
                    frame_stamp = it.now_ms;
                    draw_frame();
                    for (int i = 0; i < StripLen; i++) begin
                        px.pixel_index   = 4'(i);
                        px.red           = frame_rgb[i][0];
                        px.green         = frame_rgb[i][1];
                        px.blue          = frame_rgb[i][2];
                        px.brightness    = shown_level;
                        px.pattern_shown = shown;
                        px.last          = (i == StripLen - 1);
                        expected_pixels.push_back(px);
                    end
                end
                // rotation timer
                if (it.now_ms - rotate_stamp >= rotate_gap && may_change) begin
                    rotate_stamp = it.now_ms;
                    shown_level = strip_level;
                    if (!holding) begin
                        p = cur_pat + 1;
                        while (is_locked(p)) p++;
                        if (p > TopPat) p = 0;
                        cur_pat = 4'(p);
                        steps = 0;
                    end else if (release_armed) begin
                        release_cnt++;
                        if (release_cnt > 10) begin
                            release_armed = 1'b0;
                            holding = 1'b0;
                            release_cnt = 0;
                        end
                    end
                end
            end
        endcase
    endfunction

    // input driver
    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire) begin
            if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
                i_in_valid   <= 1'b1;
                i_kind       <= pending_cmds[0].kind;
                i_now_ms     <= pending_cmds[0].now_ms;
                i_pattern_id <= pending_cmds[0].pattern_id;
                pending_cmds.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < IdlePct);
    end

    // accept items, check pixels, watchdog
    always @(posedge i_clk) begin
        cmd_item_t   got;
        pixel_item_t want;
        in_fire <= i_in_valid && !o_in_stall && i_rst_n;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            got.kind       = i_kind;
            got.now_ms     = i_now_ms;
            got.pattern_id = i_pattern_id;
            predict_item(got);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel %0d rgb %0d %0d %0d", o_pixel_index,
                             o_red, o_green, o_blue);
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_index !== want.pixel_index || o_red !== want.red ||
                    o_green !== want.green || o_blue !== want.blue ||
                    o_brightness !== want.brightness ||
                    o_pattern_shown !== want.pattern_shown || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: exp idx %0d rgb %0d %0d %0d bri %0d pat %0d last %0d, got idx %0d rgb %0d %0d %0d bri %0d pat %0d last %0d",
                                 want.pixel_index, want.red, want.green, want.blue,
                                 want.brightness, want.pattern_shown, want.last,
                                 o_pixel_index, o_red, o_green, o_blue,
                                 o_brightness, o_pattern_shown, o_last);
                end
            end
        end
        // only stuck while work is outstanding
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (pending_cmds.size() == 0 && !i_in_valid && expected_pixels.size() == 0))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= StuckMax) begin
            $display("led_pattern_sequencer_tb failed");
            $finish;
        end
    end

    task automatic cfg_write(input lps_pkg::t_cfg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lps_pkg::CFG_BASE_RED:     user_r = data[7:0];
            lps_pkg::CFG_BASE_GREEN:   user_g = data[7:0];
            lps_pkg::CFG_BASE_BLUE:    user_b = data[7:0];
            lps_pkg::CFG_GLOBAL_BRI:   strip_level = data[7:0];
            lps_pkg::CFG_FRAME_INT:    frame_gap = data[15:0];
            lps_pkg::CFG_ROTATION_INT: rotate_gap = data;
            lps_pkg::CFG_UNLOCK_MASK:  unlocked = data[3:0];
            default: lfsr = data;
        endcase
    endtask

    task automatic set_all(input logic [23:0] rgb, input logic [7:0] bri,
                           input logic [15:0] fgap, input logic [31:0] rgap,
                           input logic [3:0] mask, input logic [31:0] seed);
        cfg_write(lps_pkg::CFG_BASE_RED, rgb[23:16]);
        cfg_write(lps_pkg::CFG_BASE_GREEN, rgb[15:8]);
        cfg_write(lps_pkg::CFG_BASE_BLUE, rgb[7:0]);
        cfg_write(lps_pkg::CFG_GLOBAL_BRI, bri);
        cfg_write(lps_pkg::CFG_FRAME_INT, fgap);
        cfg_write(lps_pkg::CFG_ROTATION_INT, rgap);
        cfg_write(lps_pkg::CFG_UNLOCK_MASK, mask);
        cfg_write(lps_pkg::CFG_RANDOM_SEED, seed);
    endtask

    task automatic push_cmd(input logic [1:0] kind, input logic [31:0] now,
                            input logic [3:0] pid);
        cmd_item_t it;
        it.kind       = kind;
        it.now_ms     = now;
        it.pattern_id = pid;
        pending_cmds.push_back(it);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_cmds.size() > 0 || i_in_valid || expected_pixels.size() > 0);
        repeat (SettleCyc) @(negedge i_clk);
    endtask

    // random mix: mostly ticks marching forward, some commands
    task automatic random_run(input int count, input int unsigned max_step, input logic jumpy);
        int unsigned roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
                clock_ms += jumpy ? $urandom() : $urandom_range(max_step);
                push_cmd(lps_pkg::KIND_TICK, clock_ms, 4'($urandom()));
            end else if (roll < 87) begin
                // favor wheel then pulse so the pulse sees large counters
                push_cmd(lps_pkg::KIND_HOLD, $urandom(),
                         ($urandom_range(2) == 0) ? 4'd11 :
                         ($urandom_range(2) == 0) ? 4'd8 : 4'($urandom()));
            end else if (roll < 94) begin
                push_cmd(lps_pkg::KIND_RANDOM, $urandom(), 4'($urandom()));
            end else begin
                push_cmd(lps_pkg::KIND_RESUME, $urandom(), 4'($urandom()));
            end
        end
    endtask

    initial begin
        logic [3:0] held[9] = '{4'd0, 4'd3, 4'd5, 4'd8, 4'd9, 4'd10, 4'd11, 4'd13, 4'd15};
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = lps_pkg::CFG_BASE_RED;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_kind       = lps_pkg::KIND_TICK;
        i_now_ms     = '0;
        i_pattern_id = '0;
        i_out_stall  = 1'b0;

        // reset values of the shadow
        user_r = 8'd255; user_g = 8'd255; user_b = 8'd255;
        strip_level = 8'd30; frame_gap = 16'd100; rotate_gap = 32'd10000;
        unlocked = 4'd0;
        cur_pat = 4'd1; steps = '0; speed = 7'd1;
        frame_stamp = '0; rotate_stamp = '0;
        may_change = 1'b1; holding = 1'b0; release_armed = 1'b0; release_cnt = '0;
        shown_level = 8'd30; lfsr = 32'd1;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each held pattern, clamping, random pick, resume, top time
        clock_ms = 0;
        foreach (held[k]) begin
            clock_ms += 20000;
            push_cmd(lps_pkg::KIND_HOLD, 32'hFFFF_FFFF, held[k]);
            push_cmd(lps_pkg::KIND_TICK, clock_ms, 4'hF);
        end
        push_cmd(lps_pkg::KIND_RANDOM, 32'd0, 4'd0);
        push_cmd(lps_pkg::KIND_TICK, clock_ms + 30000, 4'd0);
        push_cmd(lps_pkg::KIND_RESUME, 32'd0, 4'd0);
        push_cmd(lps_pkg::KIND_TICK, 32'hFFFF_FFFF, 4'd0);
        push_cmd(lps_pkg::KIND_TICK, 32'd40, 4'd0);
        drain();

        // every register at its extremes, then mid and default settings
        set_all(24'hFF0080, 8'd255, 16'd0, 32'd0, 4'hF, 32'hFFFF_FFFF);
        random_run(48, 3, 1'b0);
        drain();

        set_all(24'h000000, 8'd0, 16'd3, 32'd15, 4'h5, 32'd0);
        random_run(48, 40, 1'b0);
        drain();

        set_all(24'hC811FF, 8'd77, 16'd1, 32'd40, 4'hA, $urandom() | 32'd1);
        clock_ms = 32'hFFFF_F000;
        random_run(48, 30, 1'b0);
        drain();

        set_all(24'h123456, 8'd200, 16'd65535, 32'hFFFF_FFFF, 4'h0, 32'd1);
        random_run(40, 0, 1'b1);
        drain();

        set_all(24'hFFFFFF, 8'd30, 16'd100, 32'd10000, 4'h3, 32'd1);
        calm = 1'b1;
        random_run(40, 300, 1'b0);
        drain();
        calm = 1'b0;
        random_run(40, 300, 1'b0);
        drain();

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("led_pattern_sequencer_tb passed");
        else
            $display("led_pattern_sequencer_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
